@@ rtl/fspr_pkg.sv @@
// Shared types and constants for the serial port register block.
// Used by fspr_fifo and fifo_serial_port_registers_top; no dependencies.
package fspr_pkg;

  typedef enum logic [1:0] {
    CMD_BUS_READ  = 2'd0,
    CMD_BUS_WRITE = 2'd1,
    CMD_LINE_RX   = 2'd2,
    CMD_LINE_TX   = 2'd3
  } fspr_cmd_e;

  typedef enum logic [2:0] {
    REG_DATA   = 3'd0,
    REG_FLAG   = 3'd1,
    REG_RAW    = 3'd2,
    REG_CLEAR  = 3'd3,
    REG_MASK   = 3'd4,
    REG_MASKED = 3'd5
  } fspr_reg_e;

  // Bit positions in the flag register.
  localparam int unsigned FlagTxEmpty = 3;
  localparam int unsigned FlagTxFull  = 2;
  localparam int unsigned FlagRxEmpty = 1;
  localparam int unsigned FlagRxFull  = 0;

  // Interrupt bits in raw status and mask.
  localparam logic [1:0] IntTx = 2'b10;
  localparam logic [1:0] IntRx = 2'b01;

  typedef struct packed {
    logic empty;
    logic full;
  } fspr_fifo_status_t;

endpackage

@@ rtl/fifo_serial_port_registers_top.sv @@
// Top level of the serial port register block.
// Depends on fspr_pkg and fspr_fifo (which uses fspr_ram).
//
// Usage. Each input word carries one command: a bus read or bus write of one
// of six registers (data, flag, raw status, clear, mask, masked status), a byte
// delivered by the line into the receive FIFO, or a request from the line for
// the next byte to send. Each input word produces exactly one result word with
// the bus read data, the transmitted byte and its valid bit, and the irq level
// after the command has taken effect.
//
// Both channels use valid/ready. All FIFO pointers, counts and status bits are
// updated at the edge where the input word is accepted; the popped byte is read
// from the FIFO RAM at that same edge and joins its word in the second stage.
// The input word is registered in the middle stage and then in the result
// register, from which it is offered.
// One word is accepted every cycle while the receiver keeps taking results.
//
// When the receiver stalls, the result register holds its word and the middle
// stage fills; then ready is dropped on the input side until the result is
// taken. Nothing is lost or repeated. After reset both FIFOs are empty, the
// raw status is clear and every interrupt is masked, so none is pending.
module fifo_serial_port_registers_top import fspr_pkg::*; #(
  parameter int unsigned FIFO_DEPTH = 32
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [1:0] cmd_i,
  input  logic [2:0] reg_index_i,
  input  logic [7:0] wdata_i,
  input  logic [7:0] rx_byte_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [7:0] rdata_o,
  output logic       tx_valid_o,
  output logic [7:0] tx_byte_o,
  output logic       irq_o
);

  logic              accept;
  logic              s1_advance;
  fspr_fifo_status_t tx_status, rx_status;
  logic [7:0]        tx_ram_data, rx_ram_data;
  logic              is_read, is_write, is_data;
  logic              tx_push, tx_pop, rx_push, rx_pop;
  logic [1:0]        raw_q, raw_d;
  logic [1:0]        mask_q, mask_d;
  logic [7:0]        reg_rdata;
  logic [3:0]        flag_bits;

  // Middle stage: item control results waiting for the RAM read data.
  logic       s1_valid_q;
  logic [7:0] s1_rdata_q;
  logic       s1_rx_sel_q;
  logic       s1_tx_sel_q;
  logic       s1_irq_q;

  // Result register.
  logic       out_valid_q;
  logic [7:0] out_rdata_q;
  logic       out_tx_valid_q;
  logic [7:0] out_tx_byte_q;
  logic       out_irq_q;

  // The middle stage moves on when the result register is empty or being taken.
  assign s1_advance = !out_valid_q || out_ready_i;
  assign in_ready_o = !s1_valid_q || s1_advance;
  assign accept     = in_valid_i && in_ready_o;

  assign is_read  = (cmd_i == CMD_BUS_READ);
  assign is_write = (cmd_i == CMD_BUS_WRITE);
  assign is_data  = (reg_index_i == REG_DATA);

  assign tx_push = accept && is_write && is_data;
  assign rx_pop  = accept && is_read && is_data && !rx_status.empty;
  assign rx_push = accept && (cmd_i == CMD_LINE_RX);
  assign tx_pop  = accept && (cmd_i == CMD_LINE_TX) && !tx_status.empty;

  fspr_fifo #(.DEPTH(FIFO_DEPTH)) u_tx_fifo (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (tx_push),
    .wdata_i  (wdata_i),
    .pop_i    (tx_pop),
    .rdata_o  (tx_ram_data),
    .status_o (tx_status)
  );

  fspr_fifo #(.DEPTH(FIFO_DEPTH)) u_rx_fifo (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (rx_push),
    .wdata_i  (rx_byte_i),
    .pop_i    (rx_pop),
    .rdata_o  (rx_ram_data),
    .status_o (rx_status)
  );

  always_comb begin
    flag_bits              = '0;
    flag_bits[FlagTxEmpty] = tx_status.empty;
    flag_bits[FlagTxFull]  = tx_status.full;
    flag_bits[FlagRxEmpty] = rx_status.empty;
    flag_bits[FlagRxFull]  = rx_status.full;

    // Register reads other than data; the data byte arrives from the RAM later.
    reg_rdata = '0;
    if (is_read) begin
      case (reg_index_i)
        REG_FLAG:   reg_rdata = {4'b0000, flag_bits};
        REG_RAW:    reg_rdata = {6'b000000, raw_q};
        REG_MASK:   reg_rdata = {6'b000000, mask_q};
        REG_MASKED: reg_rdata = {6'b000000, raw_q & mask_q};
        default:    reg_rdata = '0;
      endcase
    end

    // Status after the command; the received-byte bit sets even when full.
    raw_d  = raw_q;
    mask_d = mask_q;
    if (is_write && (reg_index_i == REG_CLEAR)) begin
      raw_d = raw_q & ~wdata_i[1:0];
    end
    if (is_write && (reg_index_i == REG_MASK)) begin
      mask_d = wdata_i[1:0];
    end
    if (rx_push) begin
      raw_d = raw_d | IntRx;
    end
    if (tx_pop) begin
      raw_d = raw_d | IntTx;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      raw_q       <= '0;
      mask_q      <= '0;
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        raw_q  <= raw_d;
        mask_q <= mask_d;
      end
      if (in_ready_o) begin
        s1_valid_q <= in_valid_i;
      end
      if (s1_advance) begin
        out_valid_q <= s1_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_rdata_q  <= reg_rdata;
      s1_rx_sel_q <= rx_pop;
      s1_tx_sel_q <= tx_pop;
      s1_irq_q    <= |(raw_d & mask_d);
    end
    if (s1_advance && s1_valid_q) begin
      out_rdata_q    <= s1_rx_sel_q ? rx_ram_data : s1_rdata_q;
      out_tx_valid_q <= s1_tx_sel_q;
      out_tx_byte_q  <= s1_tx_sel_q ? tx_ram_data : 8'h00;
      out_irq_q      <= s1_irq_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign rdata_o     = out_rdata_q;
  assign tx_valid_o  = out_tx_valid_q;
  assign tx_byte_o   = out_tx_byte_q;
  assign irq_o       = out_irq_q;

  // A full middle stage behind a stalled result must hold off new input.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && out_valid_q && !out_ready_i) |-> !in_ready_o)
    else $error("input accepted while both stages are stalled");

  // A line transmit request on an empty FIFO must not select RAM data.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && (cmd_i == CMD_LINE_TX) && tx_status.empty) |=> !s1_tx_sel_q)
    else $error("transmit byte selected from an empty FIFO");

  // A transmitted byte and bus read data never belong to the same word.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && tx_valid_o) |-> (rdata_o == 8'h00))
    else $error("read data present on a line transmit result");

endmodule

@@ rtl/fspr_ram.sv @@
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module fspr_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 32,
  parameter int unsigned AW    = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ rtl/fspr_fifo.sv @@
// Byte FIFO: head pointer, fill count and a RAM holding the entries.
// Depends on fspr_pkg and fspr_ram.
module fspr_fifo import fspr_pkg::*; #(
  parameter int unsigned DEPTH = 32
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  logic [7:0]        wdata_i,
  input  logic              pop_i,
  output logic [7:0]        rdata_o,
  output fspr_fifo_status_t status_o
);

  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);

  logic [AW-1:0] head_q, head_d;
  logic [CW-1:0] count_q, count_d;
  logic          push_ok, pop_ok;
  logic [AW:0]   tail_sum;
  logic [AW-1:0] waddr;

  assign status_o.empty = (count_q == '0);
  assign status_o.full  = (count_q == CW'(DEPTH));

  assign push_ok = push_i && !status_o.full;
  assign pop_ok  = pop_i && !status_o.empty;

  // The write slot is head plus count, wrapped once at the depth.
  assign tail_sum = (AW+1)'(head_q) + (AW+1)'(count_q);

  always_comb begin
    if (tail_sum >= (AW+1)'(DEPTH)) begin
      waddr = AW'(tail_sum - (AW+1)'(DEPTH));
    end else begin
      waddr = AW'(tail_sum);
    end

    head_d = head_q;
    if (pop_ok) begin
      if (head_q == AW'(DEPTH - 1)) begin
        head_d = '0;
      end else begin
        head_d = head_q + 1'b1;
      end
    end

    count_d = count_q;
    if (push_ok && !pop_ok) begin
      count_d = count_q + 1'b1;
    end else if (pop_ok && !push_ok) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q  <= '0;
      count_q <= '0;
    end else begin
      head_q  <= head_d;
      count_q <= count_d;
    end
  end

  fspr_ram #(
    .WIDTH (8),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (push_ok),
    .waddr_i (waddr),
    .wdata_i (wdata_i),
    .re_i    (pop_ok),
    .raddr_i (head_q),
    .rdata_o (rdata_o)
  );

endmodule
